// ===== hdl/pmt_sp_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_sp_pkg
// Types and constants shared by the program map section parser files.
// ----------------------------------------------------------------------------
package pmt_sp_pkg;

  // Table id that marks a program map section.
  localparam logic [7:0] TABLE_ID_PMT = 8'h02;

  // Fixed sizes of the section layout.
  localparam logic [3:0]  HDR_LAST_IDX   = 4'd11;
  localparam logic [12:0] HDR_CONSUMED   = 13'd13;
  localparam logic [13:0] ENTRY_OVERHEAD = 14'd5;
  localparam logic [2:0]  ENTRY_LAST_IDX = 3'd4;
  localparam logic [12:0] CONSUMED_MAX   = 13'h1FFF;
  localparam logic [9:0]  ENTRY_CNT_MAX  = 10'h3FF;
  localparam logic [9:0]  ENTRY_LIMIT_RST = 10'd16;

  // Result queue.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_ENTRY     = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_BAD_TABLE = 3'd3,
    KIND_OVERFLOW  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_PINFO  = 3'd2,
    PH_ENTRY  = 3'd3,
    PH_ESSKIP = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] sect_len;
    logic [15:0] prog_no;
    logic [4:0]  ver_no;
    logic        current_next;
    logic [7:0]  sect_no;
    logic [7:0]  last_sect_no;
    logic [15:0] pid;
    logic [11:0] info_length;
    logic [7:0]  es_type;
    logic        last_of_run;
  } res_word_t;

endpackage

// ===== hdl/pmt_sp_stream_if.sv =====
// ----------------------------------------------------------------------------
// pmt_sp_stream_if
// Valid/ready channel that carries one word of a given type per handshake.
// ----------------------------------------------------------------------------
interface pmt_sp_stream_if #(
  parameter type word_t = pmt_sp_pkg::in_word_t
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ===== hdl/pmt_section_parser_core.sv =====
// ----------------------------------------------------------------------------
// pmt_section_parser_core
// Byte-serial parser for transport stream program map sections.
// ----------------------------------------------------------------------------
// Usage:
// Section bytes enter on sec_in_i, one word per handshake, with section_start
// set on the table id byte. Parsed results leave on res_out_o: a header word
// after the twelfth header byte, one word per elementary entry, and a done,
// wrong table id or too many entries word where the section ends or fails.
// The entry_limit register sits at byte address 0 of the APB-style port.
//
// Throughput is one byte per cycle while the result queue has room. Every
// byte is decoded in the cycle it is accepted: the parser state moves at that
// edge and the results it causes are written into a four-word result queue.
// A byte causes at most two results; sec_in_i is ready while the queue has
// room for two words, so with the receiver taking a word every cycle the
// input stalls only where bytes that cause two results follow each other.
//
// Reset clears the parser to idle, empties the queue and sets entry_limit to
// 16. When the receiver stalls, results wait in the queue and the input is
// held off once fewer than two queue slots are free; nothing is dropped.
// ----------------------------------------------------------------------------
module pmt_section_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmt_sp_stream_if.sink   sec_in_i,
  pmt_sp_stream_if.source res_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [9:0] entry_limit_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {22'd0, entry_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q <= pmt_sp_pkg::ENTRY_LIMIT_RST;
    end else if (cfg_wr) begin
      entry_limit_q <= pwdata[9:0];
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  pmt_sp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_idx_q, hdr_idx_d;
  logic [12:0] consumed_q, consumed_d;
  logic [11:0] skip_q, skip_d;
  logic [2:0]  ent_idx_q, ent_idx_d;
  logic [9:0]  ent_cnt_q, ent_cnt_d;
  logic [11:0] sec_len_q, sec_len_d;
  logic [15:0] prog_num_q, prog_num_d;
  logic [5:0]  ver_flags_q, ver_flags_d;
  logic [15:0] sec_nums_q, sec_nums_d;
  logic [15:0] pcr_word_q, pcr_word_d;
  logic [11:0] pinfo_len_q, pinfo_len_d;
  logic [31:0] ent_bytes_q, ent_bytes_d;

  // Results produced by the byte being accepted.
  pmt_sp_pkg::res_word_t res0, res1;
  logic [1:0]  push_n;

  // Result queue.
  pmt_sp_pkg::res_word_t fifo_q [pmt_sp_pkg::RES_DEPTH];
  logic [pmt_sp_pkg::RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [pmt_sp_pkg::RES_CNT_W-1:0] fifo_cnt_q;
  logic in_acc, out_pop;

  // Two free slots are needed since one byte may cause two results.
  assign sec_in_i.ready = (fifo_cnt_q <= pmt_sp_pkg::RES_CNT_W'(pmt_sp_pkg::RES_DEPTH - 2));
  assign in_acc         = sec_in_i.valid && sec_in_i.ready;
  assign out_pop        = res_out_o.valid && res_out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pmt_sp_pkg::PH_IDLE;
      hdr_idx_q   <= '0;
      consumed_q  <= '0;
      skip_q      <= '0;
      ent_idx_q   <= '0;
      ent_cnt_q   <= '0;
      sec_len_q   <= '0;
      prog_num_q  <= '0;
      ver_flags_q <= '0;
      sec_nums_q  <= '0;
      pcr_word_q  <= '0;
      pinfo_len_q <= '0;
      ent_bytes_q <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      consumed_q  <= consumed_d;
      skip_q      <= skip_d;
      ent_idx_q   <= ent_idx_d;
      ent_cnt_q   <= ent_cnt_d;
      sec_len_q   <= sec_len_d;
      prog_num_q  <= prog_num_d;
      ver_flags_q <= ver_flags_d;
      sec_nums_q  <= sec_nums_d;
      pcr_word_q  <= pcr_word_d;
      pinfo_len_q <= pinfo_len_d;
      ent_bytes_q <= ent_bytes_d;
    end
  end

  // --------------------------------------------------------------------------
  // Byte decode: next state and the results of this byte
  // --------------------------------------------------------------------------
  logic [7:0]  b;
  logic [11:0] ent_len;
  logic [13:0] ent_sum;
  logic        loop_chk;
  pmt_sp_pkg::res_word_t chk_res;
  logic        chk_emit;

  assign b       = sec_in_i.word.data_byte;
  assign ent_len = {ent_bytes_q[3:0], b};
  assign ent_sum = {1'b0, consumed_q} + pmt_sp_pkg::ENTRY_OVERHEAD + {2'b00, ent_len};

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    consumed_d  = consumed_q;
    skip_d      = skip_q;
    ent_idx_d   = ent_idx_q;
    ent_cnt_d   = ent_cnt_q;
    sec_len_d   = sec_len_q;
    prog_num_d  = prog_num_q;
    ver_flags_d = ver_flags_q;
    sec_nums_d  = sec_nums_q;
    pcr_word_d  = pcr_word_q;
    pinfo_len_d = pinfo_len_q;
    ent_bytes_d = ent_bytes_q;
    res0        = '0;
    res1        = '0;
    push_n      = 2'd0;
    loop_chk    = 1'b0;
    chk_res     = '0;
    chk_emit    = 1'b0;

    if (in_acc) begin
      if (sec_in_i.word.section_start) begin
        if (b != pmt_sp_pkg::TABLE_ID_PMT) begin
          res0.kind = pmt_sp_pkg::KIND_BAD_TABLE;
          push_n    = 2'd1;
          phase_d   = pmt_sp_pkg::PH_IDLE;
        end else begin
          phase_d    = pmt_sp_pkg::PH_HEADER;
          hdr_idx_d  = 4'd1;
          ent_cnt_d  = '0;
          consumed_d = '0;
          skip_d     = '0;
          ent_idx_d  = '0;
        end
      end else begin
        unique case (phase_q)
          pmt_sp_pkg::PH_HEADER: begin
            unique case (hdr_idx_q)
              4'd1:    sec_len_d   = {b[3:0], 8'd0};
              4'd2:    sec_len_d   = {sec_len_q[11:8], b};
              4'd3:    prog_num_d  = {b, 8'd0};
              4'd4:    prog_num_d  = {prog_num_q[15:8], b};
              4'd5:    ver_flags_d = b[5:0];
              4'd6:    sec_nums_d  = {b, 8'd0};
              4'd7:    sec_nums_d  = {sec_nums_q[15:8], b};
              4'd8:    pcr_word_d  = {b, 8'd0};
              4'd9:    pcr_word_d  = {pcr_word_q[15:8], b};
              4'd10:   pinfo_len_d = {b[3:0], 8'd0};
              default: pinfo_len_d = pinfo_len_q | {4'd0, b};
            endcase
            if (hdr_idx_q >= pmt_sp_pkg::HDR_LAST_IDX) begin
              res0.kind         = pmt_sp_pkg::KIND_HEADER;
              res0.sect_len     = sec_len_d;
              res0.prog_no      = prog_num_d;
              res0.ver_no       = ver_flags_d[5:1];
              res0.current_next = ver_flags_d[0];
              res0.sect_no      = sec_nums_d[15:8];
              res0.last_sect_no = sec_nums_d[7:0];
              res0.pid          = pcr_word_d;
              res0.info_length  = pinfo_len_d;
              push_n            = 2'd1;
              // At most 13 + 4095, so the count cannot saturate here.
              consumed_d = pmt_sp_pkg::HDR_CONSUMED + {1'b0, pinfo_len_d};
              hdr_idx_d  = '0;
              if (pinfo_len_d != '0) begin
                skip_d  = pinfo_len_d;
                phase_d = pmt_sp_pkg::PH_PINFO;
              end else begin
                loop_chk = 1'b1;
              end
            end else begin
              hdr_idx_d = hdr_idx_q + 4'd1;
            end
          end
          pmt_sp_pkg::PH_PINFO, pmt_sp_pkg::PH_ESSKIP: begin
            if (skip_q != '0) begin
              skip_d = skip_q - 12'd1;
            end
            if (skip_d == '0) begin
              loop_chk = 1'b1;
            end
          end
          pmt_sp_pkg::PH_ENTRY: begin
            if (ent_idx_q < pmt_sp_pkg::ENTRY_LAST_IDX) begin
              ent_bytes_d = {ent_bytes_q[23:0], b};
              ent_idx_d   = ent_idx_q + 3'd1;
            end else begin
              res0.kind        = pmt_sp_pkg::KIND_ENTRY;
              res0.es_type     = ent_bytes_q[31:24];
              res0.pid         = {3'd0, ent_bytes_q[20:8]};
              res0.info_length = ent_len;
              push_n           = 2'd1;
              ent_idx_d        = '0;
              if (ent_cnt_q < pmt_sp_pkg::ENTRY_CNT_MAX) begin
                ent_cnt_d = ent_cnt_q + 10'd1;
              end
              consumed_d = ent_sum[13] ? pmt_sp_pkg::CONSUMED_MAX : ent_sum[12:0];
              if (ent_len != '0) begin
                skip_d  = ent_len;
                phase_d = pmt_sp_pkg::PH_ESSKIP;
              end else begin
                loop_chk = 1'b1;
              end
            end
          end
          default: begin
            // Idle: bytes without a start mark are dropped.
          end
        endcase
      end
    end

    // Top of the entry loop: finish, overflow or start the next entry.
    if (loop_chk) begin
      if (consumed_d >= {1'b0, sec_len_d}) begin
        chk_res.kind = pmt_sp_pkg::KIND_DONE;
        chk_emit     = 1'b1;
        phase_d      = pmt_sp_pkg::PH_IDLE;
      end else if (ent_cnt_d >= entry_limit_q) begin
        chk_res.kind = pmt_sp_pkg::KIND_OVERFLOW;
        chk_emit     = 1'b1;
        phase_d      = pmt_sp_pkg::PH_IDLE;
      end else begin
        phase_d   = pmt_sp_pkg::PH_ENTRY;
        ent_idx_d = '0;
      end
    end

    if (chk_emit) begin
      if (push_n == 2'd0) begin
        res0   = chk_res;
        push_n = 2'd1;
      end else begin
        res1   = chk_res;
        push_n = 2'd2;
      end
    end

    if (push_n == 2'd1) begin
      res0.last_of_run = 1'b1;
    end
    if (push_n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two writes and one read per cycle
  // --------------------------------------------------------------------------
  assign wr_ptr_nx = wr_ptr_q + pmt_sp_pkg::RES_PTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_nx] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + pmt_sp_pkg::RES_PTR_W'(push_n);
      rd_ptr_q   <= rd_ptr_q + pmt_sp_pkg::RES_PTR_W'(out_pop);
      fifo_cnt_q <= fifo_cnt_q + pmt_sp_pkg::RES_CNT_W'(push_n)
                    - pmt_sp_pkg::RES_CNT_W'(out_pop);
    end
  end

  assign res_out_o.valid = (fifo_cnt_q != '0);
  assign res_out_o.word  = fifo_q[rd_ptr_q];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= pmt_sp_pkg::RES_CNT_W'(pmt_sp_pkg::RES_DEPTH))
    else $error("result queue count beyond its depth");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !sec_in_i.word.section_start && phase_q == pmt_sp_pkg::PH_IDLE)
    |-> (push_n == 2'd0))
    else $error("idle byte without start mark produced a result");

  a_start_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && sec_in_i.word.section_start && b == pmt_sp_pkg::TABLE_ID_PMT)
    |=> (phase_q == pmt_sp_pkg::PH_HEADER && hdr_idx_q == 4'd1))
    else $error("valid table id did not start the header");

  a_entry_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_idx_q <= pmt_sp_pkg::ENTRY_LAST_IDX)
    else $error("entry byte index out of range");

  a_pair_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (!res0.last_of_run && res1.last_of_run
      && (res1.kind == pmt_sp_pkg::KIND_DONE || res1.kind == pmt_sp_pkg::KIND_OVERFLOW)))
    else $error("second result of a byte is not a closing word");

endmodule

// ===== tb/tb_pmt_section_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_pmt_section_parser_core
// Self-checking regression for the program map section parser.
// ----------------------------------------------------------------------------
// Section bytes are driven into the parser one word per handshake. A model of
// the parser, kept inside this bench, decodes each accepted byte and queues
// the result words that byte must produce. A receiver process takes result
// words with random back-pressure and compares each one, field by field,
// against the oldest queued prediction. Short directed sections come first,
// then a long run of random sections, broken sections and noise under
// several entry_limit settings, and finally two cut-short sections that
// carry the largest length fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pmt_section_parser_core;

  // Register map and run bounds.
  localparam logic [2:0] ENTRY_LIMIT_ADDR = 3'd0;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned RANDOM_BYTES    = 1100;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned CFG_SPACING     = 180;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pmt_sp_stream_if #(.word_t(pmt_sp_pkg::in_word_t))  sec_if ();
  pmt_sp_stream_if #(.word_t(pmt_sp_pkg::res_word_t)) res_if ();

  pmt_section_parser_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sec_in_i  (sec_if),
    .res_out_o (res_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // --------------------------------------------------------------------------
  // Clock, cycle budget and bookkeeping.
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned busy_bytes;
  int unsigned starts_sent;
  int unsigned limit_writes;
  int unsigned kind_seen [5];

  // When set, neither the sender nor the receiver inserts idle cycles.
  bit quiet_mode;

  // Results of the byte being decoded, then all results not yet received.
  pmt_sp_pkg::res_word_t byte_results [$];
  pmt_sp_pkg::res_word_t section_results_q [$];

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: cycle budget exhausted, %0d results still outstanding",
               $time, section_results_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Gap length for either side: mostly back-to-back, sometimes a short gap,
  // rarely a long stall.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Parser model. It holds its own copy of the parser state and of
  // entry_limit, and turns every accepted byte into the result words that the
  // byte should cause, in order.
  // --------------------------------------------------------------------------
  pmt_sp_pkg::phase_e p_phase;
  logic [3:0]  p_hdr_idx;
  logic [12:0] p_consumed;
  logic [11:0] p_skip;
  logic [2:0]  p_ent_idx;
  logic [9:0]  p_ent_cnt;
  logic [11:0] p_sec_len;
  logic [15:0] p_prog_num;
  logic [5:0]  p_ver_flags;
  logic [15:0] p_sec_nums;
  logic [15:0] p_pcr;
  logic [11:0] p_pinfo_len;
  logic [31:0] p_ent_bytes;
  logic [9:0]  p_limit;

  function automatic pmt_sp_pkg::res_word_t blank_result(pmt_sp_pkg::kind_e k);
    pmt_sp_pkg::res_word_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  // The consumed count saturates instead of wrapping.
  function automatic void bump_consumed(int unsigned amount);
    int unsigned sum;
    sum = p_consumed + amount;
    p_consumed = (sum > pmt_sp_pkg::CONSUMED_MAX) ? pmt_sp_pkg::CONSUMED_MAX : sum[12:0];
  endfunction

  // Top of the entry loop: the section is complete, the entry limit has been
  // reached, or another entry is due.
  function automatic void end_or_next_entry();
    if (p_consumed >= {1'b0, p_sec_len}) begin
      byte_results.push_back(blank_result(pmt_sp_pkg::KIND_DONE));
      p_phase = pmt_sp_pkg::PH_IDLE;
    end else if (p_ent_cnt >= p_limit) begin
      byte_results.push_back(blank_result(pmt_sp_pkg::KIND_OVERFLOW));
      p_phase = pmt_sp_pkg::PH_IDLE;
    end else begin
      p_phase   = pmt_sp_pkg::PH_ENTRY;
      p_ent_idx = '0;
    end
  endfunction

  function automatic void parse_section_byte(logic [7:0] b, logic st);
    pmt_sp_pkg::res_word_t r;
    logic [11:0] es_len;
    byte_results.delete();
    if (st) begin
      if (b != pmt_sp_pkg::TABLE_ID_PMT) begin
        byte_results.push_back(blank_result(pmt_sp_pkg::KIND_BAD_TABLE));
        p_phase = pmt_sp_pkg::PH_IDLE;
      end else begin
        // A start mark always restarts parsing, even mid-section.
        p_phase    = pmt_sp_pkg::PH_HEADER;
        p_hdr_idx  = 4'd1;
        p_ent_cnt  = '0;
        p_consumed = '0;
        p_skip     = '0;
        p_ent_idx  = '0;
      end
    end else begin
      unique case (p_phase)
        pmt_sp_pkg::PH_HEADER: begin
          unique case (p_hdr_idx)
            4'd1:    p_sec_len   = {b[3:0], 8'h00};
            4'd2:    p_sec_len   = p_sec_len | {4'h0, b};
            4'd3:    p_prog_num  = {b, 8'h00};
            4'd4:    p_prog_num  = p_prog_num | {8'h00, b};
            4'd5:    p_ver_flags = b[5:0];
            4'd6:    p_sec_nums  = {b, 8'h00};
            4'd7:    p_sec_nums  = p_sec_nums | {8'h00, b};
            4'd8:    p_pcr       = {b, 8'h00};
            4'd9:    p_pcr       = p_pcr | {8'h00, b};
            4'd10:   p_pinfo_len = {b[3:0], 8'h00};
            default: p_pinfo_len = p_pinfo_len | {4'h0, b};
          endcase
          if (p_hdr_idx >= pmt_sp_pkg::HDR_LAST_IDX) begin
            r              = blank_result(pmt_sp_pkg::KIND_HEADER);
            r.sect_len     = p_sec_len;
            r.prog_no      = p_prog_num;
            r.ver_no       = p_ver_flags[5:1];
            r.current_next = p_ver_flags[0];
            r.sect_no      = p_sec_nums[15:8];
            r.last_sect_no = p_sec_nums[7:0];
            r.pid          = p_pcr;
            r.info_length  = p_pinfo_len;
            byte_results.push_back(r);
            p_consumed = '0;
            bump_consumed(13 + p_pinfo_len);
            p_hdr_idx = '0;
            if (p_pinfo_len != 0) begin
              p_skip  = p_pinfo_len;
              p_phase = pmt_sp_pkg::PH_PINFO;
            end else begin
              // Without program info the loop check runs here; an empty loop gives header and done.
              end_or_next_entry();
            end
          end else begin
            p_hdr_idx = p_hdr_idx + 4'd1;
          end
        end
        pmt_sp_pkg::PH_PINFO, pmt_sp_pkg::PH_ESSKIP: begin
          if (p_skip > 0) p_skip = p_skip - 12'd1;
          if (p_skip == 0) end_or_next_entry();
        end
        pmt_sp_pkg::PH_ENTRY: begin
          if (p_ent_idx < pmt_sp_pkg::ENTRY_LAST_IDX) begin
            p_ent_bytes = {p_ent_bytes[23:0], b};
            p_ent_idx   = p_ent_idx + 3'd1;
          end else begin
            es_len        = {p_ent_bytes[3:0], b};
            r             = blank_result(pmt_sp_pkg::KIND_ENTRY);
            r.es_type     = p_ent_bytes[31:24];
            r.pid         = {3'b000, p_ent_bytes[20:8]};
            r.info_length = es_len;
            byte_results.push_back(r);
            p_ent_idx = '0;
            if (p_ent_cnt < pmt_sp_pkg::ENTRY_CNT_MAX) p_ent_cnt = p_ent_cnt + 10'd1;
            bump_consumed(5 + es_len);
            if (es_len != 0) begin
              p_skip  = es_len;
              p_phase = pmt_sp_pkg::PH_ESSKIP;
            end else begin
              end_or_next_entry();
            end
          end
        end
        default: ;
      endcase
    end
    if (byte_results.size() > 0) begin
      r = byte_results[byte_results.size() - 1];
      r.last_of_run = 1'b1;
      byte_results[byte_results.size() - 1] = r;
    end
    foreach (byte_results[i]) section_results_q.push_back(byte_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, and each accepted result word is checked
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  int unsigned stall_left;

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, fname, want, got);
    end
  endtask

  task automatic check_result(pmt_sp_pkg::res_word_t got);
    pmt_sp_pkg::res_word_t want;
    if (section_results_q.size() == 0) begin
      error_count++;
      $display("%0t ns: unexpected result word, expected none, actual kind %0d",
               $time, got.kind);
    end else begin
      want = section_results_q.pop_front();
      kind_seen[want.kind]++;
      check_field("kind",         16'(want.kind),         16'(got.kind));
      check_field("sect_len",     16'(want.sect_len),     16'(got.sect_len));
      check_field("prog_no",      want.prog_no,           got.prog_no);
      check_field("ver_no",       16'(want.ver_no),       16'(got.ver_no));
      check_field("current_next", 16'(want.current_next), 16'(got.current_next));
      check_field("sect_no",      16'(want.sect_no),      16'(got.sect_no));
      check_field("last_sect_no", 16'(want.last_sect_no), 16'(got.last_sect_no));
      check_field("pid",          want.pid,               got.pid);
      check_field("info_length",  16'(want.info_length),  16'(got.info_length));
      check_field("es_type",      16'(want.es_type),      16'(got.es_type));
      check_field("last_of_run",  16'(want.last_of_run),  16'(got.last_of_run));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_result(res_if.word);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------

  // Sends one section byte. This task lowers valid only when a gap precedes the
  // byte, so a back-to-back word keeps valid high across the edge.
  task automatic send_byte(logic [7:0] b, logic st);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      sec_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sec_if.valid <= 1'b1;
    sec_if.word  <= '{data_byte: b, section_start: st};
    do @(posedge clk_i); while (sec_if.ready !== 1'b1);
    bytes_sent++;
    if (st) starts_sent++;
    // Bytes that arrive while idle are dropped by the parser; they do not
    // count toward the random byte budget.
    if (st || p_phase != pmt_sp_pkg::PH_IDLE) busy_bytes++;
    parse_section_byte(b, st);
  endtask

  // Holds the input off until every predicted result has been received, then
  // waits the given settle time so that a byte that caused no result is settled.
  task automatic wait_results_drained(int unsigned settle);
    sec_if.valid <= 1'b0;
    while (section_results_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ENTRY_LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes entry_limit while the parser is quiet and reads it back.
  task automatic set_entry_limit(logic [9:0] value);
    logic [31:0] rdata;
    wait_results_drained(SETTLE_CYCLES);
    apb_access(1'b1, {22'h0, value}, rdata);
    p_limit = value;
    limit_writes++;
    apb_access(1'b0, '0, rdata);
    if (rdata[9:0] !== value) begin
      error_count++;
      $display("%0t ns: entry_limit readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, value, rdata[9:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Section builder. The caller fills es_lens with the descriptor length of
  // each elementary entry; a negative sec_len means a length that matches the
  // content, and fill selects random header and entry fields (negative) or a
  // constant byte for them.
  // --------------------------------------------------------------------------
  int unsigned es_lens [$];
  logic [7:0]  section_bytes [$];

  function automatic logic [7:0] field_byte(int fill);
    if (fill < 0) return 8'($urandom_range(0, 255));
    return fill[7:0];
  endfunction

  function automatic void build_pmt(int unsigned pinfo, int sec_len, int fill);
    int unsigned total;
    logic [11:0] len_f;
    logic [11:0] pinfo_f;
    logic [11:0] es_f;
    logic [7:0]  b;
    total = 13 + pinfo;
    foreach (es_lens[i]) total += 5 + es_lens[i];
    if (sec_len < 0) len_f = (total > 4095) ? 12'hFFF : total[11:0];
    else len_f = sec_len[11:0];
    pinfo_f = pinfo[11:0];
    section_bytes.delete();
    section_bytes.push_back(pmt_sp_pkg::TABLE_ID_PMT);
    b = field_byte(fill);
    section_bytes.push_back({b[7:4], len_f[11:8]});
    section_bytes.push_back(len_f[7:0]);
    // Program number, version byte, section numbers and PCR pid word.
    repeat (7) section_bytes.push_back(field_byte(fill));
    b = field_byte(fill);
    section_bytes.push_back({b[7:4], pinfo_f[11:8]});
    section_bytes.push_back(pinfo_f[7:0]);
    repeat (pinfo) section_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (es_lens[i]) begin
      es_f = es_lens[i][11:0];
      section_bytes.push_back(field_byte(fill));
      section_bytes.push_back(field_byte(fill));
      section_bytes.push_back(field_byte(fill));
      b = field_byte(fill);
      section_bytes.push_back({b[7:4], es_f[11:8]});
      section_bytes.push_back(es_f[7:0]);
      repeat (es_lens[i]) section_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // The CRC is never read, so random bytes stand in for it.
    repeat (4) section_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Sends the first count bytes of the built section (all of them when count
  // is negative); before byte pause_at the sender holds off until drained.
  task automatic send_section(int count, int pause_at);
    int unsigned n;
    n = (count < 0) ? section_bytes.size() : count;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_results_drained(0);
      send_byte(section_bytes[i], i == 0);
    end
  endtask

  // Random content for a well-formed section, mostly small.
  function automatic int unsigned pick_pinfo();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 95) return $urandom_range(1, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic void pick_entries();
    int unsigned n;
    int unsigned roll;
    es_lens.delete();
    n = $urandom_range(0, 5);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) es_lens.push_back($urandom_range(0, 3));
      else if (roll < 95) es_lens.push_back($urandom_range(4, 12));
      else es_lens.push_back($urandom_range(13, 40));
    end
  endfunction

  function automatic logic [9:0] pick_limit();
    unique case ($urandom_range(0, 7))
      0:       return 10'd1;
      1:       return 10'd1023;
      2:       return pmt_sp_pkg::ENTRY_LIMIT_RST;
      3:       return 10'($urandom_range(1, 1023));
      default: return 10'($urandom_range(1, 5));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Start bytes other than the PMT table id, and bytes while idle.
  task automatic test_bad_table_id();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h03, 1'b1);
    send_byte(pmt_sp_pkg::TABLE_ID_PMT, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  // Sections whose loop is already complete after the header or the program
  // info; the all-ones and all-zeros header fields are covered here.
  task automatic test_empty_loop();
    es_lens.delete();
    build_pmt(0, 0, 8'hFF);
    send_section(-1, -1);
    build_pmt(0, 13, 8'h00);
    send_section(-1, -1);
    build_pmt(2, -1, -1);
    send_section(-1, -1);
  endtask

  // Entries with and without descriptors, at the field extremes.
  task automatic test_entries();
    es_lens = '{0, 3};
    build_pmt(1, -1, 8'hFF);
    send_section(-1, -1);
    es_lens = '{0};
    build_pmt(0, -1, 8'h00);
    send_section(-1, -1);
  endtask

  // A new start mark in the middle of a descriptor skip drops that section.
  task automatic test_restart();
    es_lens = '{4, 4};
    build_pmt(0, -1, -1);
    send_section(19, -1);
    build_pmt(0, -1, -1);
    send_section(-1, -1);
  endtask

  // Entry limit at its low end rejects the second entry; at its high end
  // all entries pass.
  task automatic test_entry_overflow();
    set_entry_limit(10'd1);
    es_lens = '{0, 0, 0};
    build_pmt(0, -1, -1);
    send_section(-1, -1);
    set_entry_limit(10'd1023);
    build_pmt(0, -1, -1);
    send_section(-1, -1);
    set_entry_limit(pmt_sp_pkg::ENTRY_LIMIT_RST);
  endtask

  // The sender stops mid-section until every result has come, then resumes.
  task automatic test_pressure_pause();
    es_lens = '{2, 2, 2};
    build_pmt(1, -1, -1);
    send_section(-1, 20);
  endtask

  // Mostly well-formed sections with random content, plus broken lengths,
  // truncated sections, wrong table ids and noise, under changing limits.
  task automatic test_random_traffic();
    int unsigned first_busy;
    int unsigned last_cfg;
    int unsigned roll;
    logic [7:0]  b;
    first_busy = busy_bytes;
    last_cfg   = busy_bytes;
    while (busy_bytes - first_busy < RANDOM_BYTES) begin
      if (busy_bytes - last_cfg >= CFG_SPACING) begin
        set_entry_limit(pick_limit());
        last_cfg = busy_bytes;
      end
      if ($urandom_range(0, 9) == 0) quiet_mode = ~quiet_mode;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        pick_entries();
        build_pmt(pick_pinfo(), -1, -1);
        send_section(-1, ($urandom_range(0, 24) == 0) ?
                     $urandom_range(1, section_bytes.size() - 1) : -1);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end else if (roll < 78) begin
        pick_entries();
        build_pmt(pick_pinfo(), $urandom_range(0, 300), -1);
        send_section(-1, -1);
      end else if (roll < 86) begin
        pick_entries();
        build_pmt(pick_pinfo(), -1, -1);
        send_section($urandom_range(1, section_bytes.size() - 1), -1);
      end else if (roll < 92) begin
        do b = 8'($urandom_range(0, 255)); while (b == pmt_sp_pkg::TABLE_ID_PMT);
        send_byte(b, 1'b1);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  // Largest program info length and section length in a header, then an
  // entry with the largest descriptor length. Both sections are cut short
  // once those fields have been reported, which keeps the run compact.
  task automatic test_large_sizes();
    quiet_mode = 1'b1;
    es_lens.delete();
    build_pmt(4095, 4095, -1);
    send_section(20, -1);
    es_lens = '{4095};
    build_pmt(0, 4095, -1);
    send_section(20, -1);
    quiet_mode = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    sec_if.valid = 1'b0;
    sec_if.word  = '0;
    res_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    quiet_mode   = 1'b0;
    stall_left   = 0;

    // Model state after reset.
    p_phase     = pmt_sp_pkg::PH_IDLE;
    p_hdr_idx   = '0;
    p_consumed  = '0;
    p_skip      = '0;
    p_ent_idx   = '0;
    p_ent_cnt   = '0;
    p_sec_len   = '0;
    p_prog_num  = '0;
    p_ver_flags = '0;
    p_sec_nums  = '0;
    p_pcr       = '0;
    p_pinfo_len = '0;
    p_ent_bytes = '0;
    p_limit     = pmt_sp_pkg::ENTRY_LIMIT_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_table_id();
    test_empty_loop();
    test_entries();
    test_restart();
    test_entry_overflow();
    test_pressure_pause();
    test_random_traffic();
    set_entry_limit(pmt_sp_pkg::ENTRY_LIMIT_RST);
    test_large_sizes();

    wait_results_drained(8);

    $display("Sent %0d bytes (%0d parsed, %0d section starts) under %0d entry_limit writes.",
             bytes_sent, busy_bytes, starts_sent, limit_writes);
    $display("Checked %0d headers, %0d entries, %0d done, %0d bad table, %0d overflow.",
             kind_seen[pmt_sp_pkg::KIND_HEADER], kind_seen[pmt_sp_pkg::KIND_ENTRY],
             kind_seen[pmt_sp_pkg::KIND_DONE], kind_seen[pmt_sp_pkg::KIND_BAD_TABLE],
             kind_seen[pmt_sp_pkg::KIND_OVERFLOW]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
